// ===== hw/rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

    localparam int NUM_BLOCKS_DEF    = 65536;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam int INDEX_W = 16;
    localparam int TOTAL_W = 17;
    localparam int COUNT_W = 17;
    localparam int INDEX_LIMIT = 65536;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FDB   = 1'b0;
    localparam logic REG_TOTAL = 1'b1;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd65536;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_FORMAT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef enum logic [3:0] {
        DC_NONE,
        DC_LOAD,
        DC_SWEEP_INIT,
        DC_DIV,
        DC_MUL,
        DC_UPDATE,
        DC_ALLOC_EVAL,
        DC_FMT_WRITE,
        DC_CLR_WRITE,
        DC_OOR,
        DC_NOSPACE
    } t_dp_code;

    typedef struct packed {
        t_dp_code code;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_oor;
        logic       fdb_oor;
        logic       found;
        logic       scan_end;
        logic       sweep_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Free/test: from accept to result a request passes check, word base, read, update and done.
// Allocate: check, word base, read/evaluate per map word scanned; out of range: check, done.
// Format: one map word written per cycle over all MAP_WORDS words, then done.
// One request in flight; the next can be taken in the cycle after the result is loaded.
// Reset is synchronous; afterwards all MAP_WORDS map words (2048 by default) are cleared,
// during which no request is taken; register writes are taken at any time.
`default_nettype none

module bitmap_block_allocator #(
    parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_op,
    input  wire logic [bba_pkg::INDEX_W-1:0]   i_block_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [1:0]                    o_status,
    output logic      [bba_pkg::INDEX_W-1:0]   o_result_block,
    output logic                               o_was_used,
    output logic      [bba_pkg::COUNT_W-1:0]   o_data_used,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [bba_pkg::INDEX_W-1:0] r_fdb;
    logic [bba_pkg::TOTAL_W-1:0] r_total;
    logic                        cfg_wr;
    logic                        reg_sel;
    bba_pkg::t_cmd               cmd;
    bba_pkg::t_sts               sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdb   <= '0;
            r_total <= bba_pkg::TOTAL_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == bba_pkg::REG_TOTAL) begin
                r_total <= pwdata[bba_pkg::TOTAL_W-1:0];
            end else begin
                r_fdb <= pwdata[bba_pkg::INDEX_W-1:0];
            end
        end
    end

    assign prdata = (reg_sel == bba_pkg::REG_TOTAL) ? bba_pkg::PDATA_W'(r_total)
                                                    : bba_pkg::PDATA_W'(r_fdb);

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bba_dp #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_op),
        .i_block_index  (i_block_index),
        .i_fdb          (r_fdb),
        .i_total        (r_total),
        .o_status       (o_status),
        .o_result_block (o_result_block),
        .o_was_used     (o_was_used),
        .o_data_used    (o_data_used)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bba_pkg::t_cmd      o_cmd,
    input  wire bba_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_MUL,
        S_READ,
        S_UPD,
        S_AREAD,
        S_AEVAL,
        S_FMT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd.code      = bba_pkg::DC_NONE;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.code = bba_pkg::DC_CLR_WRITE;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.code = bba_pkg::DC_LOAD;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                case (i_sts.op)
                    bba_pkg::OP_FORMAT: begin
                        o_cmd.code = bba_pkg::DC_SWEEP_INIT;
                        n_state    = S_FMT;
                    end
                    bba_pkg::OP_ALLOC: begin
                        if (i_sts.fdb_oor) begin
                            o_cmd.code = bba_pkg::DC_NOSPACE;
                            n_state    = S_DONE;
                        end else begin
                            o_cmd.code = bba_pkg::DC_DIV;
                            n_state    = S_MUL;
                        end
                    end
                    default: begin
                        if (i_sts.idx_oor) begin
                            o_cmd.code = bba_pkg::DC_OOR;
                            n_state    = S_DONE;
                        end else begin
                            o_cmd.code = bba_pkg::DC_DIV;
                            n_state    = S_MUL;
                        end
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.code = bba_pkg::DC_MUL;
                n_state    = (i_sts.op == bba_pkg::OP_ALLOC) ? S_AREAD : S_READ;
            end
            S_READ: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.code = bba_pkg::DC_UPDATE;
                n_state    = S_DONE;
            end
            S_AREAD: begin
                n_state = S_AEVAL;
            end
            S_AEVAL: begin
                o_cmd.code = bba_pkg::DC_ALLOC_EVAL;
                n_state    = (i_sts.found || i_sts.scan_end) ? S_DONE : S_AREAD;
            end
            S_FMT: begin
                o_cmd.code = bba_pkg::DC_FMT_WRITE;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHK))
        else $error("accepted request did not enter check state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while held");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

endmodule

`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
`default_nettype none

module bba_dp #(
    parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_sts                      o_sts,
    input  wire logic [1:0]                    i_op,
    input  wire logic [bba_pkg::INDEX_W-1:0]   i_block_index,
    input  wire logic [bba_pkg::INDEX_W-1:0]   i_fdb,
    input  wire logic [bba_pkg::TOTAL_W-1:0]   i_total,
    output logic      [1:0]                    o_status,
    output logic      [bba_pkg::INDEX_W-1:0]   o_result_block,
    output logic                               o_was_used,
    output logic      [bba_pkg::COUNT_W-1:0]   o_data_used
);

    localparam int W         = MAP_WORD_BITS;
    localparam int MAP_WORDS = (NUM_BLOCKS + W - 1) / W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int KW        = $clog2(W);
    localparam int BW        = $clog2(NUM_BLOCKS + W + 1);
    localparam int EW        = (BW > bba_pkg::TOTAL_W) ? BW : bba_pkg::TOTAL_W;
    localparam int IW        = bba_pkg::INDEX_W;
    localparam int TW        = bba_pkg::TOTAL_W;
    localparam int CW        = bba_pkg::COUNT_W;
    localparam int LIMIT     = (NUM_BLOCKS < bba_pkg::INDEX_LIMIT) ? NUM_BLOCKS
                                                                   : bba_pkg::INDEX_LIMIT;
    // floor(x / W) for 16-bit x as (x * RECIP) >> RSH
    localparam int RSH       = IW + KW;
    localparam int RCW       = IW + 2;
    localparam int PW        = IW + RCW;
    localparam logic [RCW-1:0] RECIP = RCW'(((64'd1 << RSH) + W - 1) / W);

    logic [1:0]     r_op;
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_q;
    logic [EW:0]    r_base;
    logic [AW-1:0]  r_word;
    logic [CW-1:0]  r_count;
    logic [1:0]     r_res_status;
    logic [IW-1:0]  r_res_block;
    logic           r_res_was;

    logic [TW-1:0]  eff_total;
    logic [IW-1:0]  fmt_lim;
    logic [IW-1:0]  div_x;
    logic [PW-1:0]  prod;
    logic [EW:0]    k_full;
    logic [KW-1:0]  k;
    logic [W-1:0]   rd_data;
    logic           rd_bit;
    logic [W-1:0]   lo_mask;
    logic [W-1:0]   hi_mask;
    logic [W-1:0]   fmt_mask;
    logic [W-1:0]   cand;
    logic [KW-1:0]  pos;
    logic           found;
    logic [EW:0]    base_next;
    logic           ram_we;
    logic [W-1:0]   ram_wdata;
    logic           do_clear_bit;

    function automatic logic [W-1:0] below(input logic [EW:0] lim, input logic [EW:0] base);
        logic [EW:0]  d;
        logic [W-1:0] m;
        d = lim - base;
        for (int j = 0; j < W; j++) begin
            m[j] = (lim > base) && (d > (EW+1)'(j));
        end
        return m;
    endfunction

    assign eff_total = (i_total > TW'(LIMIT)) ? TW'(LIMIT) : i_total;
    assign fmt_lim   = ({1'b0, i_fdb} < eff_total) ? i_fdb : IW'(eff_total);
    assign div_x     = (r_op == bba_pkg::OP_ALLOC) ? i_fdb : r_idx;
    assign prod      = PW'(div_x) * PW'(RECIP);
    assign k_full    = (EW+1)'(r_idx) - r_base;
    assign k         = k_full[KW-1:0];
    assign rd_bit    = rd_data[k];
    assign base_next = r_base + (EW+1)'(W);

    assign lo_mask  = below((EW+1)'(i_fdb), r_base);
    assign hi_mask  = below((EW+1)'(eff_total), r_base);
    assign fmt_mask = below((EW+1)'(fmt_lim), r_base);
    assign cand     = ~rd_data & ~lo_mask & hi_mask;
    assign found    = |cand;

    always_comb begin
        pos = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (cand[j]) begin
                pos = KW'(j);
            end
        end
    end

    assign do_clear_bit = (r_op == bba_pkg::OP_FREE) && rd_bit;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        case (i_cmd.code)
            bba_pkg::DC_CLR_WRITE: begin
                ram_we = 1'b1;
            end
            bba_pkg::DC_FMT_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = fmt_mask;
            end
            bba_pkg::DC_ALLOC_EVAL: begin
                ram_we    = found;
                ram_wdata = rd_data | (W'(1) << pos);
            end
            bba_pkg::DC_UPDATE: begin
                ram_we    = do_clear_bit;
                ram_wdata = rd_data & ~(W'(1) << k);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bba_ram #(
        .WIDTH (W),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_word),
        .i_wdata (ram_wdata),
        .o_rdata (rd_data)
    );

    assign o_sts.op         = r_op;
    assign o_sts.idx_oor    = ({1'b0, r_idx} >= eff_total);
    assign o_sts.fdb_oor    = ({1'b0, i_fdb} >= eff_total);
    assign o_sts.found      = found;
    assign o_sts.scan_end   = (base_next >= (EW+1)'(eff_total));
    assign o_sts.sweep_last = (r_word == AW'(MAP_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_count <= '0;
        end else begin
            case (i_cmd.code)
                bba_pkg::DC_LOAD: begin
                    r_op  <= i_op;
                    r_idx <= i_block_index;
                end
                bba_pkg::DC_SWEEP_INIT: begin
                    r_word       <= '0;
                    r_base       <= '0;
                    r_count      <= '0;
                    r_res_status <= bba_pkg::ST_OK;
                    r_res_block  <= '0;
                    r_res_was    <= 1'b0;
                end
                bba_pkg::DC_DIV: begin
                    r_q <= IW'(prod >> RSH);
                end
                bba_pkg::DC_MUL: begin
                    r_word <= AW'(r_q);
                    r_base <= (EW+1)'(r_q) * (EW+1)'(W);
                end
                bba_pkg::DC_UPDATE: begin
                    r_res_status <= bba_pkg::ST_OK;
                    r_res_block  <= r_idx;
                    r_res_was    <= rd_bit;
                    if (do_clear_bit && (r_idx >= i_fdb) && (r_count != '0)) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                bba_pkg::DC_ALLOC_EVAL: begin
                    r_res_was <= 1'b0;
                    if (found) begin
                        r_res_status <= bba_pkg::ST_OK;
                        r_res_block  <= IW'(r_base + (EW+1)'(pos));
                        if (r_count != bba_pkg::COUNT_MAX) begin
                            r_count <= r_count + CW'(1);
                        end
                    end else if (o_sts.scan_end) begin
                        r_res_status <= bba_pkg::ST_NO_SPACE;
                        r_res_block  <= '0;
                    end else begin
                        r_word <= r_word + AW'(1);
                        r_base <= base_next;
                    end
                end
                bba_pkg::DC_FMT_WRITE: begin
                    r_word <= r_word + AW'(1);
                    r_base <= base_next;
                end
                bba_pkg::DC_CLR_WRITE: begin
                    r_word <= r_word + AW'(1);
                end
                bba_pkg::DC_OOR: begin
                    r_res_status <= bba_pkg::ST_RANGE;
                    r_res_block  <= r_idx;
                    r_res_was    <= 1'b0;
                end
                bba_pkg::DC_NOSPACE: begin
                    r_res_status <= bba_pkg::ST_NO_SPACE;
                    r_res_block  <= '0;
                    r_res_was    <= 1'b0;
                end
                default: begin
                    r_word <= r_word;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status       <= r_res_status;
            o_result_block <= r_res_block;
            o_was_used     <= r_res_was;
            o_data_used    <= r_count;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;

    import bba_pkg::*;

    localparam int STALL_LIMIT = 30000;
    localparam int N_ROWS      = 32;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 52;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] result_block;
        logic               was_used;
        logic [COUNT_W-1:0] data_used;
    } t_alloc_rsp;

    typedef enum logic [1:0] {ROW_REQ, ROW_SET_FDB, ROW_SET_TOTAL} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  op;
        logic [31:0] arg;
        logic        known;
        t_alloc_rsp  rsp;
    } t_dir_row;

    // known = 1: result typed in, otherwise taken from the map model
    localparam t_dir_row DIR_ROWS [N_ROWS] = '{
        '{ROW_REQ,       OP_TEST,   32'd0,      1'b1, '{ST_OK,       16'd0,     1'b0, 17'd0}},
        '{ROW_REQ,       OP_TEST,   32'd65535,  1'b1, '{ST_OK,       16'd65535, 1'b0, 17'd0}},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b1, '{ST_OK,       16'd0,     1'b0, 17'd1}},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_FREE,   32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_FREE,   32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_SET_TOTAL, OP_ALLOC,  32'd100,    1'b0, '0},
        '{ROW_REQ,       OP_TEST,   32'd100,    1'b1, '{ST_RANGE,    16'd100,   1'b0, 17'd2}},
        '{ROW_REQ,       OP_FREE,   32'd65535,  1'b1, '{ST_RANGE,    16'd65535, 1'b0, 17'd2}},
        '{ROW_REQ,       OP_TEST,   32'd99,     1'b0, '0},
        '{ROW_SET_FDB,   OP_ALLOC,  32'd8,      1'b0, '0},
        '{ROW_REQ,       OP_FORMAT, 32'd0,      1'b1, '{ST_OK,       16'd0,     1'b0, 17'd0}},
        '{ROW_REQ,       OP_TEST,   32'd7,      1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_FREE,   32'd3,      1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_SET_FDB,   OP_ALLOC,  32'd2,      1'b0, '0},
        '{ROW_REQ,       OP_FREE,   32'd2,      1'b0, '0},
        '{ROW_REQ,       OP_FREE,   32'd4,      1'b0, '0},
        '{ROW_REQ,       OP_FREE,   32'd5,      1'b0, '0},
        '{ROW_SET_FDB,   OP_ALLOC,  32'd100,    1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b1, '{ST_NO_SPACE, 16'd0,     1'b0, 17'd0}},
        '{ROW_REQ,       OP_FORMAT, 32'd0,      1'b0, '0},
        '{ROW_SET_TOTAL, OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b1, '{ST_NO_SPACE, 16'd0,     1'b0, 17'd0}},
        '{ROW_REQ,       OP_TEST,   32'd0,      1'b1, '{ST_RANGE,    16'd0,     1'b0, 17'd0}},
        '{ROW_SET_TOTAL, OP_ALLOC,  32'd131071, 1'b0, '0},
        '{ROW_SET_FDB,   OP_ALLOC,  32'd65535,  1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_ALLOC,  32'd0,      1'b0, '0},
        '{ROW_REQ,       OP_TEST,   32'd65535,  1'b0, '0}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [1:0]           i_op          = OP_ALLOC;
    logic [INDEX_W-1:0]   i_block_index = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_status;
    logic [INDEX_W-1:0]   o_result_block;
    logic                 o_was_used;
    logic [COUNT_W-1:0]   o_data_used;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bitmap_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_block_index  (i_block_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_result_block (o_result_block),
        .o_was_used     (o_was_used),
        .o_data_used    (o_data_used),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // map model state
    bit                 occ_map [NUM_BLOCKS_DEF];
    logic [COUNT_W-1:0] used_cnt  = '0;
    logic [INDEX_W-1:0] cfg_fdb   = '0;
    logic [TOTAL_W-1:0] cfg_total = TOTAL_RESET;

    t_alloc_rsp outstanding_results [$];
    t_alloc_rsp want;
    int         err_cnt     = 0;
    int         idle_cycles = 0;
    bit         gaps_on     = 1'b1;

    function automatic int eff_total();
        return (cfg_total > INDEX_LIMIT) ? INDEX_LIMIT : int'(cfg_total);
    endfunction

    function automatic t_alloc_rsp apply_map_op(logic [1:0] op, logic [INDEX_W-1:0] idx);
        t_alloc_rsp r;
        int lim;
        lim = eff_total();
        r   = '0;
        case (op)
            OP_ALLOC: begin
                r.status = ST_NO_SPACE;
                for (int s = int'(cfg_fdb); s < lim; s++) begin
                    if (!occ_map[s]) begin
                        occ_map[s] = 1'b1;
                        if (used_cnt != COUNT_MAX) used_cnt = used_cnt + 1'b1;
                        r.status       = ST_OK;
                        r.result_block = s[INDEX_W-1:0];
                        break;
                    end
                end
            end
            OP_FREE, OP_TEST: begin
                r.result_block = idx;
                if (int'(idx) >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    r.was_used = occ_map[idx];
                    if (op == OP_FREE && r.was_used) begin
                        occ_map[idx] = 1'b0;
                        if (idx >= cfg_fdb && used_cnt != '0) used_cnt = used_cnt - 1'b1;
                    end
                end
            end
            default: begin
                if (int'(cfg_fdb) < lim) lim = int'(cfg_fdb);
                foreach (occ_map[s]) occ_map[s] = (s < lim);
                used_cnt = '0;
            end
        endcase
        r.data_used = used_cnt;
        return r;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int lim;
        int lo;
        int r;
        lim = eff_total();
        lo  = (int'(cfg_fdb) < lim) ? int'(cfg_fdb) : 0;
        r   = $urandom_range(99);
        if (r < 50) return INDEX_W'($urandom_range(lo, (lo + 80 > 65535) ? 65535 : lo + 80));
        if (r < 80) return INDEX_W'($urandom_range(0, (lim + 2 > 65535) ? 65535 : lim + 2));
        return INDEX_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_req(logic [1:0] op, logic [INDEX_W-1:0] idx, logic known,
                            t_alloc_rsp known_rsp);
        t_alloc_rsp r;
        while (gaps_on && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_block_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = apply_map_op(op, idx);
        outstanding_results.push_back(known ? known_rsp : r);
    endtask

    task automatic drain(int settle);
        i_in_valid <= 1'b0;
        while (outstanding_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_FDB) cfg_fdb = data[INDEX_W-1:0];
        else cfg_total = data[TOTAL_W-1:0];
        @(posedge i_clk);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outstanding_results.size() == 0) begin
                $error("result with no request pending: status %0d block %0d",
                       o_status, o_result_block);
                err_cnt++;
            end else begin
                want = outstanding_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
                if (o_result_block !== want.result_block) begin
                    $error("result_block: expected %0d, got %0d",
                           want.result_block, o_result_block);
                    err_cnt++;
                end
                if (o_was_used !== want.was_used) begin
                    $error("was_used: expected %0d, got %0d", want.was_used, o_was_used);
                    err_cnt++;
                end
                if (o_data_used !== want.data_used) begin
                    $error("data_used: expected %0d, got %0d",
                           want.data_used, o_data_used);
                    err_cnt++;
                end
            end
        end
        i_out_ready <= !gaps_on || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [INDEX_W-1:0] fdb_set;
        logic [TOTAL_W-1:0] total_set;
        int                 r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[k]) begin
            case (DIR_ROWS[k].kind)
                ROW_REQ: begin
                    send_req(DIR_ROWS[k].op, DIR_ROWS[k].arg[INDEX_W-1:0],
                             DIR_ROWS[k].known, DIR_ROWS[k].rsp);
                end
                ROW_SET_FDB: begin
                    drain(4);
                    apb_write(REG_FDB, DIR_ROWS[k].arg);
                end
                default: begin
                    drain(4);
                    apb_write(REG_TOTAL, DIR_ROWS[k].arg);
                end
            endcase
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin fdb_set = 16'd0;     total_set = 17'd65536;  end
                1: begin fdb_set = 16'd16;    total_set = 17'd64;     end
                2: begin fdb_set = 16'd0;     total_set = 17'd1;      end
                3: begin fdb_set = 16'd40;    total_set = 17'd48;     end
                4: begin
                    fdb_set   = INDEX_W'($urandom_range(0, 300));
                    total_set = TOTAL_W'($urandom_range(1, 1500));
                end
                5: begin fdb_set = 16'd65535; total_set = 17'd131071; end
                6: begin fdb_set = 16'd1000;  total_set = 17'd900;    end
                default: begin
                    fdb_set   = INDEX_W'($urandom_range(0, 65535));
                    total_set = TOTAL_W'($urandom_range(0, 131071));
                end
            endcase
            drain(4);
            gaps_on = (p != 3);
            apb_write(REG_FDB, 32'(fdb_set));
            apb_write(REG_TOTAL, 32'(total_set));
            if ($urandom_range(99) < 70) send_req(OP_FORMAT, pick_index(), 1'b0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 42) send_req(OP_ALLOC, pick_index(), 1'b0, '0);
                else if (r < 72) send_req(OP_FREE, pick_index(), 1'b0, '0);
                else if (r < 97) send_req(OP_TEST, pick_index(), 1'b0, '0);
                else send_req(OP_FORMAT, pick_index(), 1'b0, '0);
            end
        end

        drain(20);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
